[hdl/sst_pkg.sv]
// shared constants, codes and types of the sum segment tree
package sst_pkg;

  // tree geometry
  localparam int MAX_LEAVES = 1024;
  localparam int NODES      = 2 * MAX_LEAVES;
  localparam int NODE_W     = $clog2(NODES);
  localparam int WALK_W     = NODE_W + 1;

  // field widths
  localparam int POS_W = 10;
  localparam int CNT_W = 11;
  localparam int SUM_W = 32;

  // command codes
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one accepted beat as handed to the engine
  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] position;
    logic [SUM_W-1:0] new_value;
    logic [CNT_W-1:0] range_start;
    logic [CNT_W-1:0] range_end;
    logic [CNT_W-1:0] leaves;
  } sst_req_t;

  // engine status toward the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } sst_status_t;

endpackage

[hdl/sst_engine.sv]
// tree memory and the sequencer that walks it for sets and range queries
module sst_engine import sst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sst_req_t          req,
  input  logic              res_take,
  output sst_status_t       status,
  output logic [SUM_W-1:0]  res_sum
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SET   = 3'd2;
  localparam logic [2:0] ST_UP    = 3'd3;
  localparam logic [2:0] ST_QLO   = 3'd4;
  localparam logic [2:0] ST_QHI   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [SUM_W-1:0]  mem [NODES];
  logic [SUM_W-1:0]  rdata;

  logic [2:0]        state, state_next;
  logic [NODE_W-1:0] clr_addr;
  logic [NODE_W-1:0] node, node_next;
  logic [SUM_W-1:0]  cur, cur_next;
  logic [WALK_W-1:0] lo, lo_next;
  logic [WALK_W-1:0] hi, hi_next;
  logic [SUM_W-1:0]  acc;
  logic              acc_en;

  logic              mem_we, mem_re;
  logic [NODE_W-1:0] mem_waddr, mem_raddr;
  logic [SUM_W-1:0]  mem_wdata;

  logic [NODE_W-1:0] parent;
  logic [SUM_W-1:0]  up_sum;
  logic [CNT_W-1:0]  hi_clip;
  logic [CNT_W-1:0]  leaf_node;

  // helpers for the walk
  assign parent    = {1'b0, node[NODE_W-1:1]};
  assign up_sum    = cur + rdata;
  assign hi_clip   = (req.range_end > req.leaves) ? req.leaves : req.range_end;
  assign leaf_node = req.leaves + CNT_W'(req.position);

  // sequencer and memory port control
  always_comb begin
    state_next = state;
    node_next  = node;
    cur_next   = cur;
    lo_next    = lo;
    hi_next    = hi;
    mem_we     = 1'b0;
    mem_waddr  = node;
    mem_wdata  = cur;
    mem_re     = 1'b0;
    mem_raddr  = node ^ NODE_W'(1);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (req.cmd == CMD_SET) begin
            if (CNT_W'(req.position) < req.leaves) begin
              node_next  = NODE_W'(leaf_node);
              cur_next   = req.new_value;
              state_next = ST_SET;
            end
          end else begin
            lo_next    = WALK_W'(req.range_start) + WALK_W'(req.leaves);
            hi_next    = WALK_W'(hi_clip) + WALK_W'(req.leaves);
            state_next = ST_QLO;
          end
        end
      end
      ST_SET: begin
        // write the leaf and fetch its sibling
        mem_we = 1'b1;
        if (|node[NODE_W-1:1]) begin
          mem_re     = 1'b1;
          state_next = ST_UP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_UP: begin
        // parent gets the sum of both children, next sibling read overlaps
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_sum;
        cur_next  = up_sum;
        node_next = parent;
        if (|parent[NODE_W-1:1]) begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ NODE_W'(1);
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_QLO: begin
        // left edge: take an odd left node and step right
        if (lo < hi) begin
          if (lo[0]) begin
            mem_re    = 1'b1;
            mem_raddr = NODE_W'(lo);
            lo_next   = lo + WALK_W'(1);
          end
          state_next = ST_QHI;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_QHI: begin
        // right edge: take the node left of an odd bound, then climb a level
        if (hi[0]) begin
          mem_re    = 1'b1;
          mem_raddr = NODE_W'(hi - WALK_W'(1));
        end
        lo_next    = lo >> 1;
        hi_next    = hi >> 1;
        state_next = ST_QLO;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // tree store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      acc_en   <= 1'b0;
    end else begin
      state  <= state_next;
      acc_en <= mem_re && ((state == ST_QLO) || (state == ST_QHI));
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
    end
  end

  // walk registers and query accumulator
  always_ff @(posedge clk) begin
    node <= node_next;
    cur  <= cur_next;
    lo   <= lo_next;
    hi   <= hi_next;
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if (acc_en) begin
      acc <= acc + rdata;
    end
  end

  assign status.idle      = (state == ST_IDLE);
  assign status.res_valid = (state == ST_DONE);
  assign res_sum          = acc;

endmodule

[hdl/sum_segment_tree.sv]
// top level of the sum segment tree: handshakes, leaf count register, result register
// set: writes the leaf and each ancestor up to the root before taking the next beat;
//   a set outside the leaf count leaves the engine idle, so the input stays free
// query: one left-edge and one right-edge step per tree level; the walk is bound by
//   the single read port of the tree memory
// one item at a time; a finished result waits in the output register meanwhile
// reset starts a clearing pass over the 2048 tree memory words; in_stall stays high
//   during it, leaf_count writes are taken at any time
module sum_segment_tree import sst_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [POS_W-1:0]        position,
  input  logic signed [SUM_W-1:0] new_value,
  input  logic [CNT_W-1:0]        range_start,
  input  logic [CNT_W-1:0]        range_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] range_sum,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_wdata
);

  logic [CNT_W-1:0] leaf_count;
  logic [CNT_W-1:0] leaves;
  sst_req_t         req;
  sst_status_t      status;
  logic             start;
  logic             res_take;
  logic [SUM_W-1:0] res_sum;

  // leaf count register
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= CNT_W'(MAX_LEAVES);
    end else if (cfg_we) begin
      leaf_count <= cfg_wdata;
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    leaves = leaf_count;
    if (leaf_count == '0) begin
      leaves = CNT_W'(1);
    end else if (leaf_count > CNT_W'(MAX_LEAVES)) begin
      leaves = CNT_W'(MAX_LEAVES);
    end
  end

  // input beat
  assign in_stall        = !status.idle;
  assign start           = in_valid && !in_stall;
  assign req.cmd         = cmd;
  assign req.position    = position;
  assign req.new_value   = new_value;
  assign req.range_start = range_start;
  assign req.range_end   = range_end;
  assign req.leaves      = leaves;

  // output slot frees when empty or when its beat is taken
  assign res_take = !out_valid || !out_stall;

  sst_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .res_take (res_take),
    .status   (status),
    .res_sum  (res_sum)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= status.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && status.res_valid) begin
      range_sum <= res_sum;
    end
  end

endmodule

[hdl/sst_checker.sv]
// port-level checks for the sum segment tree and their binding
module sst_checker import sst_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    cmd,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [SUM_W-1:0] range_sum
);

  // reset always leads into the clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled after reset");

  // one item at a time: an accepted query beat stalls the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_QUERY) |=> in_stall)
    else $error("input taken while an item is at work");

  // a set beat never brings a result
  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_SET) && !out_valid |=> !out_valid)
    else $error("result appeared after a set");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(range_sum))
    else $error("stalled result changed");

endmodule

bind sum_segment_tree sst_checker u_sst_checker (.*);

[tb/sv/tb_sum_segment_tree.sv]
// self-checking testbench of the sum segment tree: directed and random set and range-sum beats
`timescale 1ns / 100ps

module tb_sum_segment_tree;
  import sst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 86;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic             cmd;
    logic [POS_W-1:0] position;
    logic [SUM_W-1:0] new_value;
    logic [CNT_W-1:0] range_start;
    logic [CNT_W-1:0] range_end;
  } sst_beat_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    cmd = CMD_SET;
  logic [POS_W-1:0]        position = '0;
  logic signed [SUM_W-1:0] new_value = '0;
  logic [CNT_W-1:0]        range_start = '0;
  logic [CNT_W-1:0]        range_end = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SUM_W-1:0] range_sum;
  logic                    cfg_we = 1'b0;
  logic [CNT_W-1:0]        cfg_wdata = '0;

  // beats waiting to be driven and range sums waiting to come out
  sst_beat_t        pending_beats[$];
  logic [SUM_W-1:0] expected_sums[$];

  // shadow of the tree and of the leaf count register
  logic [SUM_W-1:0] node_sum[0:NODES-1];
  logic [CNT_W-1:0] leaf_reg;

  int send_idle_pct = 25;
  int recv_stall_pct = 86;
  int error_count = 0;
  int cycle_count = 0;

  sum_segment_tree dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .position    (position),
    .new_value   (new_value),
    .range_start (range_start),
    .range_end   (range_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .range_sum   (range_sum),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always #5 clk = ~clk;

  // leaf count in force: zero acts as one, anything above the maximum is capped
  function automatic int unsigned active_leaves(logic [CNT_W-1:0] reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > MAX_LEAVES) return MAX_LEAVES;
    return 32'(reg_val);
  endfunction

  // write one leaf and rebuild its ancestors
  function automatic void tree_write(int unsigned n, int unsigned pos, logic [SUM_W-1:0] val);
    int unsigned node;
    if (pos >= n) return;
    node = pos + n;
    node_sum[node] = val;
    while (node > 1) begin
      node_sum[node >> 1] = node_sum[node] + node_sum[node ^ 1];
      node = node >> 1;
    end
  endfunction

  // wrapping sum over leaves [lo, hi), end clamped to the leaf count
  function automatic logic [SUM_W-1:0] tree_range_sum(int unsigned n, int unsigned lo,
                                                      int unsigned hi);
    logic [SUM_W-1:0] acc;
    acc = '0;
    if (hi > n) hi = n;
    if (lo >= hi) return '0;
    lo = lo + n;
    hi = hi + n;
    while (lo < hi) begin
      if (lo[0]) begin
        acc = acc + node_sum[lo];
        lo = lo + 1;
      end
      if (hi[0]) begin
        hi = hi - 1;
        acc = acc + node_sum[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  // random beat, mostly shaped to the active leaf count, sometimes anywhere in the field
  function automatic sst_beat_t random_beat(int unsigned n);
    sst_beat_t b;
    int unsigned a;
    int unsigned c;
    b.cmd = $urandom_range(1) ? CMD_QUERY : CMD_SET;
    b.position = POS_W'($urandom_range(MAX_LEAVES - 1));
    case ($urandom_range(7))
      0: b.new_value = 32'h7FFF_FFFF;
      1: b.new_value = 32'h8000_0000;
      2: b.new_value = 32'hFFFF_FFFF;
      3: b.new_value = $urandom_range(20);
      default: b.new_value = $urandom();
    endcase
    b.range_start = CNT_W'($urandom_range(MAX_LEAVES));
    b.range_end = CNT_W'($urandom_range(MAX_LEAVES));
    if ($urandom_range(99) < 85) begin
      b.position = POS_W'($urandom_range(n - 1));
      a = $urandom_range(n);
      c = $urandom_range(n);
      b.range_start = CNT_W'((a < c) ? a : c);
      b.range_end = CNT_W'((a < c) ? c : a);
    end
    return b;
  endfunction

  function automatic void add_set(int unsigned pos, logic [SUM_W-1:0] val);
    sst_beat_t b;
    b.cmd = CMD_SET;
    b.position = POS_W'(pos);
    b.new_value = val;
    b.range_start = CNT_W'($urandom_range(MAX_LEAVES));
    b.range_end = CNT_W'($urandom_range(MAX_LEAVES));
    pending_beats.push_back(b);
  endfunction

  function automatic void add_query(int unsigned lo, int unsigned hi);
    sst_beat_t b;
    b.cmd = CMD_QUERY;
    b.position = POS_W'($urandom_range(MAX_LEAVES - 1));
    b.new_value = $urandom();
    b.range_start = CNT_W'(lo);
    b.range_end = CNT_W'(hi);
    pending_beats.push_back(b);
  endfunction

  task automatic write_leaf_count(input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block quiet: nothing queued, nothing on the input, no sum outstanding, engine settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input beat driver, predicts each accepted beat
  always @(posedge clk) begin : drive_proc
    sst_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
      leaf_reg = CNT_W'(MAX_LEAVES);
      for (int i = 0; i < NODES; i++) node_sum[i] = '0;
    end else begin
      if (cfg_we) leaf_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (cmd == CMD_SET)
          tree_write(active_leaves(leaf_reg), 32'(position), new_value);
        else
          expected_sums.push_back(tree_range_sum(active_leaves(leaf_reg), 32'(range_start),
                                                 32'(range_end)));
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          b = pending_beats.pop_front();
          in_valid <= 1'b1;
          cmd <= b.cmd;
          position <= b.position;
          new_value <= b.new_value;
          range_start <= b.range_start;
          range_end <= b.range_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall
  always @(posedge clk) begin : watch_proc
    logic [SUM_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          $error("range_sum: expected no beat, got %0d", range_sum);
          error_count++;
        end else begin
          want = expected_sums.pop_front();
          if (range_sum !== want) begin
            $error("range_sum: expected %0d, got %0d", $signed(want), range_sum);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [CNT_W-1:0] leaf_plan[12];
    int unsigned n;
    leaf_plan = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd1024, 11'd7, 11'd2047, 11'd16,
                  11'd100, 11'd513, 11'd1023, 11'd1024};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full tree: extreme values, wrap of the total, empty and edge ranges
    write_leaf_count(CNT_W'(MAX_LEAVES));
    add_set(0, 32'h7FFF_FFFF);
    add_set(MAX_LEAVES - 1, 32'h8000_0000);
    add_set(1, 32'hFFFF_FFFF);
    add_set(512, 32'd1);
    add_query(0, MAX_LEAVES);
    add_query(0, 2);
    add_query(MAX_LEAVES - 1, MAX_LEAVES);
    add_query(0, 1);
    add_query(5, 5);
    add_query(900, 3);
    add_query(MAX_LEAVES, MAX_LEAVES);
    add_query(1, MAX_LEAVES - 1);
    add_set(0, 32'd0);
    add_query(0, MAX_LEAVES);
    wait_idle();

    // five leaves over the old store: sets out of range ignored, range end clamped
    write_leaf_count(11'd5);
    add_set(5, 32'd9);
    add_set(MAX_LEAVES - 1, 32'd7);
    add_set(4, -32'sd5);
    add_query(0, MAX_LEAVES);
    add_query(2, 1000);
    add_query(0, 5);
    add_query(5, MAX_LEAVES);
    add_query(4, 5);
    wait_idle();

    // random phases over several leaf counts and idle patterns
    foreach (leaf_plan[p]) begin
      if (p < 4) begin
        send_idle_pct = 25;
        recv_stall_pct = 86;
      end else if (p < 8) begin
        send_idle_pct = 86;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_leaf_count(leaf_plan[p]);
      n = active_leaves(leaf_plan[p]);
      repeat (PHASE_BEATS) pending_beats.push_back(random_beat(n));
      wait_idle();
    end

    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
hdl/sst_pkg.sv
hdl/sst_engine.sv
hdl/sum_segment_tree.sv
hdl/sst_checker.sv
tb/sv/tb_sum_segment_tree.sv
